@@ rtl/script_line_lexer_macros.svh @@
// Assertion helpers for the script line lexer checker.
`ifndef SCRIPT_LINE_LEXER_MACROS_SVH
`define SCRIPT_LINE_LEXER_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define SLL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define SLL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sll_pkg.sv @@
package sll_pkg;

    // Longest token text kept, in bytes
    localparam int TOKEN_CHARS = 32;

    localparam int LEN_W      = $clog2(TOKEN_CHARS + 1);
    localparam int TEXT_IW    = (TOKEN_CHARS > 1) ? $clog2(TOKEN_CHARS) : 1;
    localparam int TEXT_AW    = TEXT_IW + 1;
    localparam int TEXT_DEPTH = 2 ** TEXT_AW;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam int KIND_W    = 5;
    localparam int NUM_WORDS = 23;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 5'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT      = 5'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER     = 5'd2;
    localparam logic [KIND_W-1:0] KIND_SQ         = 5'd3;
    localparam logic [KIND_W-1:0] KIND_DQ         = 5'd4;
    localparam logic [KIND_W-1:0] KIND_END        = 5'd5;
    localparam int                KIND_TABLE_BASE = 6;

    typedef logic [NUM_WORDS-1:0] t_match;

    // One token to replay
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  len;
        logic              bank;
        logic              inl;
        logic              missing;
        logic              run_last;
        logic [7:0]        chr;
    } t_cmd;

    typedef struct packed {
        logic va;
        t_cmd a;
        logic vb;
        t_cmd b;
    } t_push;

    typedef struct packed {
        logic               en;
        logic [TEXT_AW-1:0] addr;
        logic [7:0]         data;
    } t_wr;

    typedef struct packed {
        logic               en;
        logic [TEXT_AW-1:0] addr;
    } t_rd;

    typedef struct packed {
        logic en;
        logic bank;
    } t_rel;

    // Keyword and operator table, text right-justified
    function automatic logic [47:0] word_text(input int i);
        logic [47:0] t;
        case (i)
            0:       t = 48'("echo");
            1:       t = 48'("exec");
            2:       t = 48'("exit");
            3:       t = 48'("if");
            4:       t = 48'("goto");
            5:       t = 48'("number");
            6:       t = 48'("string");
            7:       t = 48'("+");
            8:       t = 48'("-");
            9:       t = 48'("*");
            10:      t = 48'("/");
            11:      t = 48'("=");
            12:      t = 48'("==");
            13:      t = 48'("!=");
            14:      t = 48'(">");
            15:      t = 48'(">=");
            16:      t = 48'("<");
            17:      t = 48'("<=");
            18:      t = 48'("$");
            19:      t = 48'(",");
            20:      t = 48'("(");
            21:      t = 48'(")");
            22:      t = 48'(":");
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [5:0] word_len(input int i);
        logic [5:0] n;
        case (i)
            0, 1, 2, 4:         n = 6'd4;
            5, 6:               n = 6'd6;
            3, 12, 13, 15, 17:  n = 6'd2;
            default:            n = 6'd1;
        endcase
        return n;
    endfunction

    // Narrow the candidate set by one appended byte at position pos
    function automatic t_match match_step(input t_match m, input logic [LEN_W-1:0] pos,
                                          input logic [7:0] c);
        t_match      r;
        logic [5:0]  n;
        logic [47:0] txt;
        logic [2:0]  q;
        logic [5:0]  base;
        for (int i = 0; i < NUM_WORDS; i++) begin
            n    = word_len(i);
            txt  = word_text(i);
            q    = 3'(n - 6'(pos) - 6'd1);
            base = {q, 3'b000};
            r[i] = ((pos == '0) || m[i]) && (6'(pos) < n) && (txt[base +: 8] == c);
        end
        return r;
    endfunction

    // Kind of a finished token, or the fallback when nothing matches
    function automatic logic [KIND_W-1:0] lookup_kind(input t_match m,
                                                     input logic [LEN_W-1:0] len,
                                                     input logic [KIND_W-1:0] fallback);
        logic [KIND_W-1:0] k;
        k = fallback;
        for (int i = NUM_WORDS - 1; i >= 0; i--) begin
            if (m[i] && (word_len(i) == 6'(len))) begin
                k = KIND_W'(KIND_TABLE_BASE + i);
            end
        end
        return k;
    endfunction

endpackage

@@ rtl/sll_ram.sv @@
module sll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/sll_front.sv @@
module sll_front
    import sll_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    input  logic       i_room,
    input  t_rel       i_rel,
    output t_push      o_push,
    output t_wr        o_wr
);

    typedef enum logic [5:0] {
        M_IDLE    = 6'b000001,
        M_IDENT   = 6'b000010,
        M_NUMBER  = 6'b000100,
        M_COMP    = 6'b001000,
        M_STRING  = 6'b010000,
        M_COMMENT = 6'b100000
    } t_mode;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_EQ   = "=";
    localparam logic [7:0] CH_HASH = "#";
    localparam logic [7:0] CH_SQ   = "'";
    localparam logic [7:0] CH_DQ   = "\"";

    t_mode            r_mode, n_mode;
    logic [LEN_W-1:0] r_len, n_len;
    t_match           r_match, n_match;
    logic             r_bank, n_bank;
    logic             r_quote, n_quote;
    logic [1:0]       r_busy, n_busy;

    logic is_sp, is_dig, is_alpha, is_idc, is_cmp, is_quote, is_close;
    logic acc, open, can_app;
    logic app_cur, close_tok, go_idle, emit_a, app_new, push_b, flip, bank_i;
    logic [KIND_W-1:0] a_kind, b_kind;
    logic [LEN_W-1:0]  a_len, b_len;
    logic              a_missing;
    logic [7:0]        b_chr;
    t_mode             new_mode;
    t_match            app_match, new_match, one_match;

    // Classify the byte
    always_comb begin
        is_sp    = i_ch inside {8'd32, [8'd9:8'd13]};
        is_dig   = i_ch inside {["0":"9"]};
        is_alpha = i_ch inside {["a":"z"], ["A":"Z"]};
        is_idc   = is_alpha || is_dig || (i_ch == "_");
        is_cmp   = i_ch inside {">", "<", "=", "!"};
        is_quote = i_ch inside {CH_SQ, CH_DQ};
        is_close = (i_ch == (r_quote ? CH_DQ : CH_SQ));
    end

    assign open    = r_mode inside {M_IDENT, M_NUMBER, M_COMP, M_STRING};
    assign can_app = (r_len < LEN_W'(TOKEN_CHARS));
    assign o_stall = (open && r_busy[~r_bank]) || !i_room;
    assign acc     = i_valid && !o_stall;

    assign app_match = match_step(r_match, r_len, i_ch);
    assign new_match = match_step(r_match, '0, i_ch);
    assign one_match = new_match;

    // Next lexer state and the tokens this byte finishes
    always_comb begin
        n_mode    = r_mode;
        n_len     = r_len;
        n_match   = r_match;
        n_quote   = r_quote;
        app_cur   = 1'b0;
        close_tok = 1'b0;
        go_idle   = 1'b0;
        emit_a    = 1'b0;
        a_kind    = KIND_UNKNOWN;
        a_len     = r_len;
        a_missing = 1'b0;
        app_new   = 1'b0;
        new_mode  = M_IDLE;
        push_b    = 1'b0;
        b_kind    = KIND_END;
        b_len     = '0;
        b_chr     = '0;

        case (r_mode)
            M_IDENT: begin
                if (is_idc) begin
                    app_cur = 1'b1;
                end else begin
                    emit_a  = 1'b1;
                    a_kind  = lookup_kind(r_match, r_len, KIND_IDENT);
                    go_idle = 1'b1;
                end
            end
            M_NUMBER: begin
                if (is_dig) begin
                    app_cur = 1'b1;
                end else begin
                    emit_a  = 1'b1;
                    a_kind  = KIND_NUMBER;
                    go_idle = 1'b1;
                end
            end
            M_COMP: begin
                emit_a = 1'b1;
                if ((i_ch == CH_EQ) && (TOKEN_CHARS > 1)) begin
                    // join the trailing '=' and close the comparator
                    app_cur   = 1'b1;
                    close_tok = 1'b1;
                    a_len     = r_len + LEN_W'(can_app);
                    a_kind    = lookup_kind(can_app ? app_match : r_match, a_len,
                                            KIND_UNKNOWN);
                end else begin
                    a_kind  = lookup_kind(r_match, r_len, KIND_UNKNOWN);
                    go_idle = 1'b1;
                end
            end
            M_STRING: begin
                if (i_ch == CH_NUL) begin
                    emit_a    = 1'b1;
                    a_kind    = r_quote ? KIND_DQ : KIND_SQ;
                    a_missing = 1'b1;
                    go_idle   = 1'b1;
                end else if (is_close) begin
                    emit_a    = 1'b1;
                    a_kind    = r_quote ? KIND_DQ : KIND_SQ;
                    close_tok = 1'b1;
                end else begin
                    app_cur = 1'b1;
                end
            end
            M_COMMENT: begin
                if (i_ch == CH_NUL) begin
                    n_mode = M_IDLE;
                    n_len  = '0;
                end
            end
            M_IDLE: begin
                go_idle = 1'b1;
            end
            default: begin
                go_idle = 1'b1;
            end
        endcase

        if (app_cur && can_app) begin
            n_len   = r_len + LEN_W'(1);
            n_match = app_match;
        end
        if (close_tok) begin
            n_len  = '0;
            n_mode = M_IDLE;
        end

        // Handle the byte as the first one between tokens
        if (go_idle) begin
            n_len  = '0;
            n_mode = M_IDLE;
            if (i_ch == CH_NUL) begin
                push_b = 1'b1;
            end else if (is_sp) begin
                n_mode = M_IDLE;
            end else if (is_alpha) begin
                app_new  = 1'b1;
                new_mode = M_IDENT;
            end else if (is_dig) begin
                app_new  = 1'b1;
                new_mode = M_NUMBER;
            end else if (i_ch == CH_HASH) begin
                push_b = 1'b1;
                n_mode = M_COMMENT;
            end else if (is_cmp) begin
                app_new  = 1'b1;
                new_mode = M_COMP;
            end else if (is_quote) begin
                n_quote = (i_ch == CH_DQ);
                n_mode  = M_STRING;
            end else begin
                push_b = 1'b1;
                b_kind = lookup_kind(one_match, LEN_W'(1), KIND_UNKNOWN);
                b_len  = LEN_W'(1);
                b_chr  = i_ch;
            end
        end
        if (app_new) begin
            n_len   = LEN_W'(1);
            n_match = new_match;
            n_mode  = new_mode;
        end
    end

    // A stored token moves the writer to the other text bank
    assign flip   = emit_a && (a_len != '0);
    assign bank_i = r_bank ^ flip;
    assign n_bank = bank_i;

    // Track banks that still hold text waiting for replay
    always_comb begin
        n_busy = r_busy;
        if (i_rel.en) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        if (acc && flip) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    // Text write
    always_comb begin
        o_wr.en   = acc && ((app_cur && can_app) || app_new);
        o_wr.addr = app_new ? {bank_i, TEXT_IW'(0)} : {r_bank, r_len[TEXT_IW-1:0]};
        o_wr.data = i_ch;
    end

    // Commands to the replay side
    always_comb begin
        o_push.va         = acc && emit_a;
        o_push.a.kind     = a_kind;
        o_push.a.len      = a_len;
        o_push.a.bank     = r_bank;
        o_push.a.inl      = 1'b0;
        o_push.a.missing  = a_missing;
        o_push.a.run_last = !push_b;
        o_push.a.chr      = '0;
        o_push.vb         = acc && push_b;
        o_push.b.kind     = b_kind;
        o_push.b.len      = b_len;
        o_push.b.bank     = bank_i;
        o_push.b.inl      = 1'b1;
        o_push.b.missing  = 1'b0;
        o_push.b.run_last = 1'b1;
        o_push.b.chr      = b_chr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_len   <= '0;
            r_bank  <= 1'b0;
            r_quote <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_busy <= n_busy;
            if (acc) begin
                r_mode  <= n_mode;
                r_len   <= n_len;
                r_bank  <= n_bank;
                r_quote <= n_quote;
            end
        end
    end

    // Candidate set follows the kept text
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_match <= n_match;
        end
    end

endmodule

@@ rtl/sll_cmdq.sv @@
module sll_cmdq
    import sll_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output t_cmd  o_head,
    output logic  o_head_valid,
    output logic  o_room
);

    t_cmd               r_ent [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_rd, r_wr;
    logic [CMDQ_CW-1:0] r_cnt;
    logic [CMDQ_AW-1:0] wr_b;
    logic               pop;

    assign o_head       = r_ent[r_rd];
    assign o_head_valid = (r_cnt != '0);
    assign o_room       = (r_cnt <= CMDQ_CW'(CMDQ_DEPTH - 2));
    assign pop          = i_pop && o_head_valid;
    assign wr_b         = r_wr + CMDQ_AW'(i_push.va);

    // Store up to two items a cycle, in order
    always_ff @(posedge i_clk) begin
        if (i_push.va) begin
            r_ent[r_wr] <= i_push.a;
        end
        if (i_push.vb) begin
            r_ent[wr_b] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + CMDQ_AW'(i_push.va) + CMDQ_AW'(i_push.vb);
            r_rd  <= r_rd + CMDQ_AW'(pop);
            r_cnt <= r_cnt + CMDQ_CW'(i_push.va) + CMDQ_CW'(i_push.vb) - CMDQ_CW'(pop);
        end
    end

endmodule

@@ rtl/sll_back.sv @@
module sll_back
    import sll_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_head,
    input  logic              i_head_valid,
    output logic              o_pop,
    output t_rel              o_rel,
    output t_rd               o_rd,
    input  logic [7:0]        i_rd_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_kind,
    output logic [7:0]        o_text_byte,
    output logic              o_has_byte,
    output logic              o_missing_quote,
    output logic              o_token_last,
    output logic              o_run_last
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              has_byte;
        logic              missing;
        logic              token_last;
        logic              run_last;
        logic              from_ram;
        logic [7:0]        chr;
    } t_item;

    logic             r_cur_valid;
    t_cmd             r_cur;
    logic [LEN_W-1:0] r_idx;
    logic             r_s1_valid;
    t_item            r_s1;
    logic             r_out_valid;
    t_item            r_out;
    logic [7:0]       r_out_text;

    logic  adv_out, can_issue, issue, cur_last, cur_ram, last_issue;
    t_item item;

    assign adv_out    = !r_out_valid || !i_stall;
    assign can_issue  = !r_s1_valid || adv_out;
    assign issue      = r_cur_valid && can_issue;
    assign cur_last   = (r_cur.len == '0) || (r_idx == r_cur.len - LEN_W'(1));
    assign cur_ram    = (r_cur.len != '0) && !r_cur.inl;
    assign last_issue = issue && cur_last;
    assign o_pop      = i_head_valid && (!r_cur_valid || last_issue);

    // Free the text bank once its last byte is read
    assign o_rel.en   = last_issue && cur_ram;
    assign o_rel.bank = r_cur.bank;

    assign o_rd.en   = issue && cur_ram;
    assign o_rd.addr = {r_cur.bank, r_idx[TEXT_IW-1:0]};

    // Attributes of the item being issued
    always_comb begin
        item.kind       = r_cur.kind;
        item.has_byte   = (r_cur.len != '0);
        item.missing    = r_cur.missing;
        item.token_last = cur_last;
        item.run_last   = r_cur.run_last && cur_last;
        item.from_ram   = cur_ram;
        item.chr        = r_cur.inl ? r_cur.chr : 8'h00;
    end

    // Advance through the current token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_valid <= 1'b1;
            end else if (last_issue) begin
                r_cur_valid <= 1'b0;
            end
            if (can_issue) begin
                r_s1_valid <= issue;
            end
            if (adv_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
            r_idx <= '0;
        end else if (issue) begin
            r_idx <= r_idx + LEN_W'(1);
        end
        if (issue) begin
            r_s1 <= item;
        end
        if (adv_out && r_s1_valid) begin
            r_out      <= r_s1;
            r_out_text <= r_s1.from_ram ? i_rd_data : r_s1.chr;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_text_byte     = r_out_text;
    assign o_has_byte      = r_out.has_byte;
    assign o_missing_quote = r_out.missing;
    assign o_token_last    = r_out.token_last;
    assign o_run_last      = r_out.run_last;

endmodule

@@ rtl/script_line_lexer.sv @@
// Results pass the command queue, then the replay token, issue and output registers.
// Throughput: one byte in per cycle; one replay result per cycle while i_stall is low;
// input stalls while a token is open and the other text bank still replays, or the
// four-entry command queue has fewer than two free slots.
// Reset: synchronous, active low; clears lexer, queue and replay control. Text RAM is
// not cleared; it is only read after being written.
module script_line_lexer
    import sll_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_ch,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [KIND_W-1:0] o_kind,
    output logic [7:0]        o_text_byte,
    output logic              o_has_byte,
    output logic              o_missing_quote,
    output logic              o_token_last,
    output logic              o_run_last
);

    t_push      push;
    t_wr        wr;
    t_rd        rd;
    t_rel       rel;
    t_cmd       head;
    logic       head_valid, pop, room;
    logic [7:0] rd_data;

    // Lexer front
    sll_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_ch    (i_ch),
        .i_room  (room),
        .i_rel   (rel),
        .o_push  (push),
        .o_wr    (wr)
    );

    // Two banks of token text
    sll_ram #(
        .WIDTH (8),
        .DEPTH (TEXT_DEPTH)
    ) u_text (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.addr),
        .i_wr_data (wr.data),
        .i_rd_en   (rd.en),
        .i_rd_addr (rd.addr),
        .o_rd_data (rd_data)
    );

    // Token command queue
    sll_cmdq u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_room       (room)
    );

    // Token replay
    sll_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_head_valid    (head_valid),
        .o_pop           (pop),
        .o_rel           (rel),
        .o_rd            (rd),
        .i_rd_data       (rd_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_text_byte     (o_text_byte),
        .o_has_byte      (o_has_byte),
        .o_missing_quote (o_missing_quote),
        .o_token_last    (o_token_last),
        .o_run_last      (o_run_last)
    );

endmodule

@@ rtl/sll_checker.sv @@
`include "script_line_lexer_macros.svh"

module sll_checker
    import sll_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [KIND_W-1:0] o_kind,
    input logic [7:0]        o_text_byte,
    input logic              o_has_byte,
    input logic              o_missing_quote,
    input logic              o_token_last,
    input logic              o_run_last
);

    // A stalled result item holds
    `SLL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_kind) && $stable(o_text_byte) && $stable(o_has_byte) && $stable(o_run_last), "stalled item changed")

    // An empty token is a single item
    `SLL_ASSERT_IMP(a_empty_last, i_clk, i_rst_n, o_valid && !o_has_byte, o_token_last, "empty token not last")

    // The last item of a byte closes its token
    `SLL_ASSERT_IMP(a_run_tok, i_clk, i_rst_n, o_valid && o_run_last, o_token_last, "run ends inside a token")

    // Only strings can lack their closing quote
    `SLL_ASSERT_IMP(a_quote_kind, i_clk, i_rst_n, o_valid && o_missing_quote, (o_kind == KIND_SQ) || (o_kind == KIND_DQ), "missing quote on non-string")

    // End token is empty and closes the byte
    `SLL_ASSERT_IMP(a_end_shape, i_clk, i_rst_n, o_valid && (o_kind == KIND_END), !o_has_byte && o_run_last, "malformed end token")

endmodule

bind script_line_lexer sll_checker u_sll_checker (.*);
